// ----- rtl/ett_pkg.sv -----
// Shared types and constants for the eased tween interpolator.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package ett_pkg;

   localparam int VALUE_W   = 32;   // Q16.16 values
   localparam int TICK_W    = 16;   // tick counts
   localparam int CSR_IDX_W = 8;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_VALUE    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_VALUE      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EASING_MODE    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION_TICKS = 8'd3;

   // 1.70158 with 32 fraction bits, rounded
   localparam logic [32:0] BACK_C2_Q32 = 33'd7308230452;

   typedef enum logic [2:0] {
      MODE_LINEAR   = 3'd0,
      MODE_IN       = 3'd1,
      MODE_OUT      = 3'd2,
      MODE_IN_OUT   = 3'd3,
      MODE_OUT_BACK = 3'd4,
      MODE_BOUNCE   = 3'd5
   } mode_type;

   // datapath commands, one per cycle
   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_LOAD      = 4'd1,   // accept word, update elapsed, seed divider
      OP_DIV_STEP  = 4'd2,   // one quotient bit
      OP_MUL_SQ    = 4'd3,   // square for in / out / in-out / bounce
      OP_SHAPE     = 4'd4,   // form shaped ratio from square (from the ratio for linear)
      OP_MUL_UU    = 4'd5,
      OP_MUL_U2U   = 4'd6,
      OP_MUL_C2U2  = 4'd7,
      OP_MUL_C1U3  = 4'd8,
      OP_BACK_END  = 4'd9,
      OP_MUL_FINAL = 4'd10,  // |end-start| * |shaped|
      OP_TERM      = 4'd11,  // scale and apply sign
      OP_OUT       = 4'd12   // add start, saturate, load output register
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic     dur_zero;
      mode_type mode;
      logic     out_free;
   } status_type;

   typedef struct packed {
      logic [TICK_W-1:0] delta_ticks;
      logic              restart;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] current_value;
      logic                      finished;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/ett_ctrl.sv -----
// Sequencer for the eased tween interpolator: issues one datapath command a cycle.
// Depends on ett_pkg.
`default_nettype none

module ett_ctrl #(
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ett_pkg::status_type status,
   output ett_pkg::cmd_type    cmd
);

   localparam int CW = $clog2(RATIO_FRAC_BITS + 1);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_DIV    = 12'b0000_0000_0010,
      ST_SQ     = 12'b0000_0000_0100,
      ST_SHAPE  = 12'b0000_0000_1000,
      ST_BK_UU  = 12'b0000_0001_0000,
      ST_BK_U2U = 12'b0000_0010_0000,
      ST_BK_C2  = 12'b0000_0100_0000,
      ST_BK_C1  = 12'b0000_1000_0000,
      ST_BK_END = 12'b0001_0000_0000,
      ST_FMUL   = 12'b0010_0000_0000,
      ST_TERM   = 12'b0100_0000_0000,
      ST_OUT    = 12'b1000_0000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd.op    = ett_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = ett_pkg::OP_LOAD;
               cnt_in   = CW'(RATIO_FRAC_BITS);
               state_in = status.dur_zero ? ST_OUT : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = ett_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               if (status.mode == ett_pkg::MODE_LINEAR) begin
                  state_in = ST_SHAPE;
               end else if (status.mode == ett_pkg::MODE_OUT_BACK) begin
                  state_in = ST_BK_UU;
               end else begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            cmd.op   = ett_pkg::OP_MUL_SQ;
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            cmd.op   = ett_pkg::OP_SHAPE;
            state_in = ST_FMUL;
         end
         ST_BK_UU: begin
            cmd.op   = ett_pkg::OP_MUL_UU;
            state_in = ST_BK_U2U;
         end
         ST_BK_U2U: begin
            cmd.op   = ett_pkg::OP_MUL_U2U;
            state_in = ST_BK_C2;
         end
         ST_BK_C2: begin
            cmd.op   = ett_pkg::OP_MUL_C2U2;
            state_in = ST_BK_C1;
         end
         ST_BK_C1: begin
            cmd.op   = ett_pkg::OP_MUL_C1U3;
            state_in = ST_BK_END;
         end
         ST_BK_END: begin
            cmd.op   = ett_pkg::OP_BACK_END;
            state_in = ST_FMUL;
         end
         ST_FMUL: begin
            cmd.op   = ett_pkg::OP_MUL_FINAL;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            cmd.op   = ett_pkg::OP_TERM;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.op   = ett_pkg::OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DIV || state_ff == ST_OUT)
      else $error("accepted word did not start division or zero-duration output");

   a_out_returns_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && status.out_free |=> state_ff == ST_IDLE)
      else $error("output issued but sequencer not back in idle");

endmodule

`default_nettype wire

// ----- rtl/ett_dpath.sv -----
// Datapath for the eased tween interpolator: config registers, elapsed count,
// serial divider, shared multiplier, easing shaping and output register. Depends on ett_pkg.
`default_nettype none

module ett_dpath #(
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ett_pkg::cmd_type                     cmd,
   output ett_pkg::status_type                  status,
   input  ett_pkg::req_type                     req_data,
   input  logic                                 csr_write,
   input  logic [ett_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ett_pkg::VALUE_W-1:0]          csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ett_pkg::rsp_type                     rsp_data
);

   localparam int F     = RATIO_FRAC_BITS;
   localparam int VW    = ett_pkg::VALUE_W;
   localparam int TKW   = ett_pkg::TICK_W;
   localparam int RW    = F + 1;          // ratio, 0..2^F
   localparam int SW    = F + 3;          // signed shaped ratio
   localparam int MAW   = VW + 1;         // multiplier port A
   localparam int MBW   = F + 5;          // multiplier port B
   localparam int PW    = MAW + MBW;
   localparam int TW    = PW - F + 1;     // signed scaled term
   localparam int OW    = TW + 1;         // start + term

   localparam logic [RW-1:0]  ONE  = {1'b1, {F{1'b0}}};
   localparam logic [RW-1:0]  C2   = RW'(ett_pkg::BACK_C2_Q32 >> (32 - F));
   localparam logic [RW:0]    C1   = {1'b0, C2} + {1'b0, ONE};
   // bounce segment bounds on 11r, and k*q offsets on 22r
   localparam logic [MBW-1:0] B4   = {5'd4, {F{1'b0}}};
   localparam logic [MBW-1:0] B8   = {5'd8, {F{1'b0}}};
   localparam logic [MBW-1:0] B10  = {5'd10, {F{1'b0}}};
   localparam logic [MBW-1:0] K12  = {5'd12, {F{1'b0}}};
   localparam logic [MBW-1:0] K18  = {5'd18, {F{1'b0}}};
   localparam logic [MBW-1:0] K21  = {5'd21, {F{1'b0}}};
   localparam logic [RW-1:0]  ADD1 = RW'(3) << (F - 2);
   localparam logic [RW-1:0]  ADD2 = RW'(15) << (F - 4);
   localparam logic [RW-1:0]  ADD3 = RW'(63) << (F - 6);

   // control state and configuration
   logic [TKW-1:0]          elapsed_ff, elapsed_in;
   logic [TKW-1:0]          dur_ff;
   logic signed [VW-1:0]    start_ff, end_ff;
   ett_pkg::mode_type       mode_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload
   logic [TKW:0]            rem_ff, rem_in;
   logic [RW-1:0]           r_ff;
   logic [RW-1:0]           u2_ff, u3_ff;
   logic [RW:0]             t2_ff;
   logic signed [SW-1:0]    s_ff, s_in;
   logic [PW-1:0]           prod_ff;
   logic                    neg_ff;
   logic signed [TW-1:0]    term_ff, term_in;
   ett_pkg::rsp_type        rsp_ff, rsp_in;

   // elapsed update
   logic [TKW-1:0]          base;
   logic [TKW:0]            sum17;
   // divider
   logic                    div_ge;
   logic [TKW:0]            rem_sub;
   // shaping helpers
   logic [RW-1:0]           u, t, sq, sel;
   logic [RW:0]             r2;
   logic                    lo_half;
   logic [MBW-1:0]          r11, r22, kq, d;
   logic [RW-1:0]           b_add;
   logic [SW-1:0]           io_hi;
   // multiplier
   logic [MAW-1:0]          mul_a;
   logic [MBW-1:0]          mul_b;
   logic [PW-1:0]           product;
   // final scaling
   logic signed [VW:0]      diff;
   logic [MAW-1:0]          diff_mag;
   logic [SW-1:0]           s_mag;
   logic [TW-2:0]           term_mag;
   logic signed [OW-1:0]    out_sum;
   logic [VW-1:0]           out_val;
   logic [2:0]              mode_wr;

   assign status.dur_zero = (dur_ff == '0);
   assign status.mode     = mode_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   // elapsed = min(base + delta, duration), base 0 on restart, at 17 bits
   always_comb begin
      base       = req_data.restart ? '0 : elapsed_ff;
      sum17      = {1'b0, base} + {1'b0, req_data.delta_ticks};
      elapsed_in = (sum17 > {1'b0, dur_ff}) ? dur_ff : sum17[TKW-1:0];
   end

   // restoring divide: compare, subtract, shift
   always_comb begin
      div_ge  = (rem_ff >= {1'b0, dur_ff});
      rem_sub = div_ge ? rem_ff - {1'b0, dur_ff} : rem_ff;
      rem_in  = {rem_sub[TKW-1:0], 1'b0};
   end

   always_comb begin
      u       = ONE - r_ff;
      r2      = {r_ff, 1'b0};
      lo_half = (r2 < {1'b0, ONE});
      t       = RW'(r2 - {1'b0, ONE});
      sq      = prod_ff[F +: RW];
      sel     = lo_half ? r_ff : t;
   end

   // bounce segment: d = |22r - k*q|
   always_comb begin
      r11 = MBW'({r_ff, 3'b000}) + MBW'({r_ff, 1'b0}) + MBW'(r_ff);
      r22 = {r11[MBW-2:0], 1'b0};
      if (r11 < B4) begin
         kq    = '0;
         b_add = '0;
      end else if (r11 < B8) begin
         kq    = K12;
         b_add = ADD1;
      end else if (r11 < B10) begin
         kq    = K18;
         b_add = ADD2;
      end else begin
         kq    = K21;
         b_add = ADD3;
      end
      d = (r22 >= kq) ? r22 - kq : kq - r22;
   end

   always_comb begin
      diff     = $signed({end_ff[VW-1], end_ff}) - $signed({start_ff[VW-1], start_ff});
      diff_mag = diff[VW] ? MAW'(-diff) : MAW'(diff);
      s_mag    = s_ff[SW-1] ? SW'(-s_ff) : SW'(s_ff);
   end

   // shared multiplier, one product per cycle
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         ett_pkg::OP_MUL_SQ: begin
            if (mode_ff == ett_pkg::MODE_BOUNCE) begin
               mul_a = MAW'(d);
               mul_b = d;
            end else if (mode_ff == ett_pkg::MODE_IN_OUT) begin
               mul_a = MAW'(sel);
               mul_b = MBW'(sel);
            end else begin
               mul_a = MAW'(r_ff);
               mul_b = MBW'(r_ff);
            end
         end
         ett_pkg::OP_MUL_UU: begin
            mul_a = MAW'(u);
            mul_b = MBW'(u);
         end
         ett_pkg::OP_MUL_U2U: begin
            mul_a = MAW'(sq);
            mul_b = MBW'(u);
         end
         ett_pkg::OP_MUL_C2U2: begin
            mul_a = MAW'(C2);
            mul_b = MBW'(u2_ff);
         end
         ett_pkg::OP_MUL_C1U3: begin
            mul_a = MAW'(C1);
            mul_b = MBW'(u3_ff);
         end
         ett_pkg::OP_MUL_FINAL: begin
            mul_a = diff_mag;
            mul_b = MBW'(s_mag);
         end
         default: begin
         end
      endcase
      product = PW'(mul_a) * PW'(mul_b);
   end

   // shaped ratio
   always_comb begin
      io_hi = {1'b0, t, 1'b0} - {2'b00, sq} + {2'b00, ONE};
      if (cmd.op == ett_pkg::OP_BACK_END) begin
         s_in = $signed({2'b00, ONE}) + $signed({1'b0, t2_ff})
                - $signed({1'b0, prod_ff[F +: RW+1]});
      end else begin
         case (mode_ff)
            ett_pkg::MODE_IN:     s_in = $signed({2'b00, sq});
            ett_pkg::MODE_OUT:    s_in = $signed({1'b0, r_ff, 1'b0} - {2'b00, sq});
            ett_pkg::MODE_IN_OUT: begin
               if (lo_half) begin
                  s_in = $signed({2'b00, prod_ff[F-1 +: RW]});
               end else begin
                  s_in = $signed({1'b0, io_hi[SW-1:1]});
               end
            end
            ett_pkg::MODE_BOUNCE: s_in = $signed({2'b00, prod_ff[F+6 +: RW]})
                                         + $signed({2'b00, b_add});
            default:              s_in = $signed({2'b00, r_ff});
         endcase
      end
   end

   // scaled term and saturated output
   always_comb begin
      term_mag = prod_ff[PW-1:F];
      term_in  = neg_ff ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
      out_sum  = $signed({{(OW-VW){start_ff[VW-1]}}, start_ff})
                 + $signed({term_ff[TW-1], term_ff});
      if (out_sum[OW-1:VW-1] != {(OW-VW+1){out_sum[OW-1]}}) begin
         out_val = out_sum[OW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      end else begin
         out_val = out_sum[VW-1:0];
      end
      rsp_in.current_value = status.dur_zero ? end_ff : $signed(out_val);
      rsp_in.finished      = (elapsed_ff == dur_ff);
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      if (cmd.op == ett_pkg::OP_OUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign mode_wr = csr_data[2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         dur_ff       <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         mode_ff      <= ett_pkg::MODE_LINEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            elapsed_ff <= '0;
            unique case (csr_index)
               ett_pkg::CSR_START_VALUE:    start_ff <= $signed(csr_data);
               ett_pkg::CSR_END_VALUE:      end_ff   <= $signed(csr_data);
               ett_pkg::CSR_EASING_MODE: begin
                  mode_ff <= (mode_wr > 3'(ett_pkg::MODE_BOUNCE)) ? ett_pkg::MODE_BOUNCE
                             : ett_pkg::mode_type'(mode_wr);
               end
               ett_pkg::CSR_DURATION_TICKS: dur_ff   <= csr_data[TKW-1:0];
               default: begin
               end
            endcase
         end else if (cmd.op == ett_pkg::OP_LOAD) begin
            elapsed_ff <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         ett_pkg::OP_LOAD:     rem_ff <= {1'b0, elapsed_in};
         ett_pkg::OP_DIV_STEP: begin
            rem_ff <= rem_in;
            r_ff   <= {r_ff[RW-2:0], div_ge};
         end
         ett_pkg::OP_MUL_SQ:   prod_ff <= product;
         ett_pkg::OP_MUL_UU:   prod_ff <= product;
         ett_pkg::OP_MUL_U2U: begin
            u2_ff   <= sq;
            prod_ff <= product;
         end
         ett_pkg::OP_MUL_C2U2: begin
            u3_ff   <= sq;
            prod_ff <= product;
         end
         ett_pkg::OP_MUL_C1U3: begin
            t2_ff   <= prod_ff[F +: RW+1];
            prod_ff <= product;
         end
         ett_pkg::OP_SHAPE:    s_ff <= s_in;
         ett_pkg::OP_BACK_END: s_ff <= s_in;
         ett_pkg::OP_MUL_FINAL: begin
            prod_ff <= product;
            neg_ff  <= diff[VW] ^ s_ff[SW-1];
         end
         ett_pkg::OP_TERM:     term_ff <= term_in;
         ett_pkg::OP_OUT:      rsp_ff  <= rsp_in;
         default: begin
         end
      endcase
   end

   a_elapsed_clamped: assert property (@(posedge clock) disable iff (reset)
      elapsed_ff <= dur_ff)
      else $error("elapsed count above duration");

   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == ett_pkg::OP_MUL_FINAL |-> r_ff <= ONE)
      else $error("ratio above one at final multiply");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == ett_pkg::OP_OUT |=> rsp_valid_ff)
      else $error("output load did not raise rsp_valid");

endmodule

`default_nettype wire

// ----- rtl/eased_tween_interpolator.sv -----
// Top level of the eased tween interpolator: ties the sequencer to the datapath.
// Depends on ett_pkg, ett_ctrl and ett_dpath.
`default_nettype none

// Tween generator for one animated scalar. Each req word carries a tick delta
// (and a restart bit); the block adds it to an elapsed count clamped at the
// programmed duration, forms ratio = elapsed * 2^F / duration, shapes it with
// the selected easing curve (linear, quadratic in/out/in-out, out-back with
// overshoot, out-bounce) and returns start + (end - start) * shaped, truncated
// toward zero and saturated to signed 32 bits, as one rsp word. finished is set
// once elapsed has reached the duration. A zero duration returns end_value.
// Timing: one word at a time. After the idle cycle that takes the word, the
// sequencer runs the bit-serial restoring divider (F = RATIO_FRAC_BITS), then
// for linear the shaping step, for the quadratic curves and bounce a square
// and the shaping step, and for out-back the products u*u, u^2*u, c2*u^2 and
// c1*u^3 and an end step; then the final multiply, the term step and the rsp
// load, which waits until the output register is free. A zero duration goes
// straight to the rsp load. Products pass through the single shared
// 33 x (F+5) multiplier, one product per cycle. req_ready is high whenever
// the sequencer is idle, even while an earlier rsp word still waits in the
// output register. CSR writes are always taken (csr_ready tied high), any
// write clears the elapsed count, and they belong in idle time only.
// Index 0 start_value, 1 end_value, 2 easing_mode (6 and 7 store as 5),
// 3 duration_ticks; higher indexes only clear elapsed.
module eased_tween_interpolator #(
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // tick words in
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ett_pkg::req_type              req_data,
   // interpolated words out
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ett_pkg::rsp_type              rsp_data,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ett_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ett_pkg::VALUE_W-1:0]   csr_data
);

   ett_pkg::cmd_type    cmd;
   ett_pkg::status_type status;
   logic                csr_write;

   // register writes never stall
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   ett_ctrl #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ett_dpath #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
